[sv/ltbp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltbp_pkg
// shared types, constants and helpers of the large turn brake/pivot sequencer
// ---------------------------------------------------------------------------
package ltbp_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BRAKE  = 2'd1,
        MODE_PIVOT  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTER_ERROR   = 3'd0,
        CFG_EXIT_ERROR    = 3'd1,
        CFG_SLOW_SPEED    = 3'd2,
        CFG_TRIGGER_TICKS = 3'd3,
        CFG_TIMEOUT_TICKS = 3'd4
    } t_cfg_idx;

    localparam logic signed [16:0] HALF_TURN = 17'sd18000;
    localparam logic signed [16:0] FULL_TURN = 17'sd36000;

    localparam logic [6:0]  TRIG_MIN = 7'd1;
    localparam logic [6:0]  TRIG_MAX = 7'd100;
    localparam logic [12:0] TMO_MIN  = 13'd10;
    localparam logic [12:0] TMO_MAX  = 13'd5000;

    localparam logic [1:0] SIGN_NONE = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    typedef struct packed {
        logic [14:0] enter_error;
        logic [14:0] exit_error;
        logic [14:0] slow_speed;
        logic [6:0]  trigger_ticks;
        logic [12:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] command_heading;
        logic               cmd_live;
        logic signed [15:0] yaw_feedback;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
    } t_in;

    typedef struct packed {
        logic [1:0]         turn_state;
        logic signed [1:0]  turn_direction;
        logic signed [15:0] yaw_target;
        logic signed [15:0] heading_err;
        logic               speed_enable;
        logic               rearm_required;
        logic               timed_out;
    } t_out;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] target_yaw;
        logic               rearm_lock;
        logic [1:0]         turn_sign;
        logic [6:0]         qualify_count;
        logic [12:0]        elapsed_count;
        logic signed [15:0] latched_target;
    } t_state;

    function automatic logic signed [16:0] wrap_once(input logic signed [16:0] a);
        logic signed [16:0] r;
        if (a > HALF_TURN) begin
            r = a - FULL_TURN;
        end else if (a < -HALF_TURN) begin
            r = a + FULL_TURN;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

[sv/large_turn_brake_pivot_sequencer_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// large_turn_brake_pivot_sequencer_unit
// yaw target keeper with normal, brake and pivot modes for large heading turns
// ---------------------------------------------------------------------------
// One item is one control tick and one result item comes back for it. Items
// are accepted every cycle unless the master side holds back; an item taken
// sits in the input register while the tick logic updates the sequencer
// state, and its result is loaded into the result register, which offers it
// on the master side. The result register holds under backpressure while
// one more item may wait in the input register. Write
// configuration only while no item is in flight.
// ---------------------------------------------------------------------------
module large_turn_brake_pivot_sequencer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // command_heading, cmd_live, yaw_feedback, left_speed, right_speed
    input  logic [ltbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // turn_state, turn_direction, yaw_target, heading_err, speed_enable,
    // rearm_required, timed_out
    output logic [ltbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ltbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ltbp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ltbp_pkg::*;

    t_cfg   cfg;
    t_in    r_in;
    logic   r_in_valid;
    t_out   r_out;
    logic   r_out_valid;
    t_state r_state;
    t_state n_state;
    t_out   n_out;
    logic   out_free;
    logic   step_go;

    assign o_cfg_ready = 1'b1;

    ltbp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ltbp_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_go       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.command_heading <= s_axis_tdata[15:0];
            r_in.cmd_live        <= s_axis_tdata[16];
            r_in.yaw_feedback    <= s_axis_tdata[32:17];
            r_in.left_speed      <= s_axis_tdata[48:33];
            r_in.right_speed     <= s_axis_tdata[64:49];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= MODE_NORMAL;
            r_state.target_yaw     <= 16'sd0;
            r_state.rearm_lock     <= 1'b0;
            r_state.turn_sign      <= SIGN_NONE;
            r_state.qualify_count  <= 7'd0;
            r_state.elapsed_count  <= 13'd0;
            r_state.latched_target <= 16'sd0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.timed_out, r_out.rearm_required,
                            r_out.speed_enable, r_out.heading_err, r_out.yaw_target,
                            r_out.turn_direction, r_out.turn_state};

endmodule

[sv/ltbp_cfg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltbp_cfg
// configuration registers; tick counts are saturated into range on write
// ---------------------------------------------------------------------------
module ltbp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ltbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ltbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ltbp_pkg::t_cfg                 o_cfg
);
    import ltbp_pkg::*;

    t_cfg        r_cfg;
    logic [6:0]  trig_w;
    logic [12:0] tmo_w;

    always_comb begin
        trig_w = i_cfg_data[6:0];
        if (trig_w < TRIG_MIN) begin
            trig_w = TRIG_MIN;
        end else if (trig_w > TRIG_MAX) begin
            trig_w = TRIG_MAX;
        end
        tmo_w = i_cfg_data[12:0];
        if (tmo_w < TMO_MIN) begin
            tmo_w = TMO_MIN;
        end else if (tmo_w > TMO_MAX) begin
            tmo_w = TMO_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_error   <= 15'd9000;
            r_cfg.exit_error    <= 15'd4500;
            r_cfg.slow_speed    <= 15'd80;
            r_cfg.trigger_ticks <= 7'd5;
            r_cfg.timeout_ticks <= 13'd500;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENTER_ERROR:   r_cfg.enter_error   <= i_cfg_data;
                CFG_EXIT_ERROR:    r_cfg.exit_error    <= i_cfg_data;
                CFG_SLOW_SPEED:    r_cfg.slow_speed    <= i_cfg_data;
                CFG_TRIGGER_TICKS: r_cfg.trigger_ticks <= trig_w;
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= tmo_w;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/ltbp_step.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltbp_step
// one control tick: command intake, large turn decision, result fields
// ---------------------------------------------------------------------------
module ltbp_step (
    input  ltbp_pkg::t_cfg   i_cfg,
    input  ltbp_pkg::t_state i_state,
    input  ltbp_pkg::t_in    i_item,
    output ltbp_pkg::t_state o_state,
    output ltbp_pkg::t_out   o_result
);
    import ltbp_pkg::*;

    logic               in_turn;
    logic signed [16:0] heading_w;
    logic signed [15:0] target_in;
    logic               lock_in;
    logic signed [16:0] err_w;
    logic [16:0]        aerr;
    logic signed [16:0] body;
    logic signed [17:0] body_x;
    logic [17:0]        abody;
    logic               slow;
    logic [12:0]        elapsed_inc;
    logic               timeout;
    logic [6:0]         qualify_nxt;
    logic [16:0]        aerr_fin;
    logic signed [16:0] err_fin;
    t_state             nxt;

    always_comb begin
        in_turn   = (i_state.mode != MODE_NORMAL);
        heading_w = wrap_once({i_item.command_heading[15], i_item.command_heading});

        // command intake
        if (in_turn) begin
            target_in = i_state.latched_target;
        end else if (i_item.cmd_live) begin
            target_in = heading_w[15:0];
        end else begin
            target_in = i_state.target_yaw;
        end
        lock_in = (!in_turn && !i_item.cmd_live) ? 1'b0 : i_state.rearm_lock;

        err_w = wrap_once({target_in[15], target_in}
                          - {i_item.yaw_feedback[15], i_item.yaw_feedback});
        aerr  = err_w[16] ? 17'(-err_w) : 17'(err_w);

        body   = {i_item.left_speed[15], i_item.left_speed}
               + {i_item.right_speed[15], i_item.right_speed};
        body_x = {body[16], body};
        abody  = body_x[17] ? 18'(-body_x) : 18'(body_x);
        slow   = (abody <= {2'b00, i_cfg.slow_speed, 1'b0});

        elapsed_inc = i_state.elapsed_count + 13'd1;
        timeout     = in_turn && (elapsed_inc >= i_cfg.timeout_ticks);

        nxt            = i_state;
        nxt.target_yaw = target_in;
        nxt.rearm_lock = lock_in;
        if (in_turn) begin
            nxt.elapsed_count = elapsed_inc;
        end
        qualify_nxt = 7'd0;

        if (timeout) begin
            nxt.mode           = MODE_NORMAL;
            nxt.turn_sign      = SIGN_NONE;
            nxt.qualify_count  = 7'd0;
            nxt.elapsed_count  = 13'd0;
            nxt.latched_target = 16'sd0;
            nxt.rearm_lock     = 1'b1;
            nxt.target_yaw     = i_item.yaw_feedback;
        end else begin
            unique case (i_state.mode)
                MODE_NORMAL: begin
                    if (!lock_in && i_item.cmd_live
                        && (aerr >= {2'b00, i_cfg.enter_error})) begin
                        qualify_nxt = (i_state.qualify_count < i_cfg.trigger_ticks)
                                    ? i_state.qualify_count + 7'd1
                                    : i_state.qualify_count;
                        nxt.qualify_count = qualify_nxt;
                        if (qualify_nxt >= i_cfg.trigger_ticks) begin
                            nxt.turn_sign      = err_w[16] ? SIGN_NEG : SIGN_POS;
                            nxt.latched_target = target_in;
                            nxt.elapsed_count  = 13'd0;
                            nxt.qualify_count  = 7'd0;
                            nxt.mode           = slow ? MODE_PIVOT : MODE_BRAKE;
                        end
                    end else begin
                        nxt.qualify_count = 7'd0;
                    end
                end
                MODE_BRAKE, MODE_PIVOT: begin
                    if (aerr <= {2'b00, i_cfg.exit_error}) begin
                        nxt.mode           = MODE_NORMAL;
                        nxt.turn_sign      = SIGN_NONE;
                        nxt.qualify_count  = 7'd0;
                        nxt.elapsed_count  = 13'd0;
                        nxt.latched_target = 16'sd0;
                    end else if (slow && i_state.mode == MODE_BRAKE) begin
                        nxt.mode = MODE_PIVOT;
                    end
                end
                default: ;
            endcase
        end

        // target after the tick is either the intake target or the feedback
        err_fin  = timeout ? 17'sd0 : err_w;
        aerr_fin = timeout ? 17'd0 : aerr;
        if ((nxt.mode == MODE_BRAKE || nxt.mode == MODE_PIVOT)
            && nxt.turn_sign != SIGN_NONE) begin
            err_fin = nxt.turn_sign[1] ? 17'(-$signed(aerr_fin)) : $signed(aerr_fin);
        end

        o_result.turn_state     = nxt.mode;
        o_result.turn_direction = nxt.turn_sign;
        o_result.yaw_target     = nxt.target_yaw;
        o_result.heading_err    = err_fin[15:0];
        o_result.speed_enable   = (nxt.mode == MODE_NORMAL) && i_item.cmd_live
                                  && !timeout;
        o_result.rearm_required = nxt.rearm_lock;
        o_result.timed_out      = timeout;
        o_state                 = nxt;
    end

endmodule
